// ===== design/efe_pkg.sv =====
// Shared types and constants for the escaped frame encoder.
package efe_pkg;

  localparam int MAX_PAYLOAD = 63;
  localparam int LEN_W       = 6;
  localparam int MAX_RES     = 5;
  localparam int IDX_W       = $clog2(MAX_RES + 1);

  localparam logic [7:0] HEAD_BYTE     = 8'hFE;
  localparam logic [7:0] TAIL_BYTE     = 8'hFF;
  localparam logic [7:0] ESC_OFFSET    = 8'd2;
  localparam logic [7:0] ERR_BYTE      = 8'h00;
  localparam logic [7:0] MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             frame_start;
    logic [LEN_W-1:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_end;
    logic       sequence_error;
  } out_item_t;

  // Line bytes of one input item, first byte in slot 0.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [MAX_RES-1:0]      tail;
    logic                    err;
    logic [IDX_W-1:0]        cnt;
  } burst_t;

endpackage

// ===== design/efe_encoder.sv =====
// Frame state and per-item encoding into a burst of line bytes.
module efe_encoder (
  input  logic              clk,
  input  logic              rst_n,
  input  efe_pkg::in_item_t item,
  input  logic              load,
  output efe_pkg::burst_t   burst
);
  import efe_pkg::*;

  logic             open_r, open_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] rem_dec;
  logic             esc;
  logic [IDX_W-1:0] idx;
  burst_t           b;

  always_comb begin
    b        = '0;
    idx      = '0;
    open_nxt = open_r;
    rem_nxt  = rem_r;
    esc      = (item.payload_byte >= HEAD_BYTE);
    len_sat  = ({2'b00, item.frame_length} > MAX_PAYLOAD_B) ?
               MAX_PAYLOAD_B[LEN_W-1:0] : item.frame_length;
    rem_dec  = (rem_r != '0) ? rem_r - LEN_W'(1) : '0;
    if (item.frame_start == open_r) begin
      // start while busy, or byte with no frame open: drop
      b.bytes[0] = ERR_BYTE;
      b.err      = 1'b1;
      idx        = IDX_W'(1);
    end else begin
      if (item.frame_start) begin
        b.bytes[idx] = HEAD_BYTE;
        idx          = idx + IDX_W'(1);
        b.bytes[idx] = 8'(len_sat);
        idx          = idx + IDX_W'(1);
      end
      if (!item.frame_start || len_sat != '0) begin
        if (esc) begin
          b.bytes[idx] = HEAD_BYTE;
          idx          = idx + IDX_W'(1);
          b.bytes[idx] = item.payload_byte - ESC_OFFSET;
        end else begin
          b.bytes[idx] = item.payload_byte;
        end
        idx = idx + IDX_W'(1);
      end
      if (item.frame_start) begin
        rem_nxt = (len_sat != '0) ? len_sat - LEN_W'(1) : '0;
      end else begin
        rem_nxt = rem_dec;
      end
      if (rem_nxt == '0) begin
        b.bytes[idx] = TAIL_BYTE;
        b.tail[idx]  = 1'b1;
        idx          = idx + IDX_W'(1);
        open_nxt     = 1'b0;
      end else begin
        open_nxt = 1'b1;
      end
    end
    b.cnt = idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rem_r  <= '0;
    end else if (load) begin
      open_r <= open_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign burst = b;

endmodule

// ===== design/efe_burst.sv =====
// Result register: holds an item's line bytes, shifts one out per unstalled cycle.
module efe_burst (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  efe_pkg::burst_t    load_data,
  input  logic               out_stall,
  output logic               can_load,
  output logic               out_valid,
  output efe_pkg::out_item_t out_item
);
  import efe_pkg::*;

  logic [MAX_RES-1:0][7:0] bytes_r, bytes_nxt;
  logic [MAX_RES-1:0]      tail_r, tail_nxt;
  logic                    err_r, err_nxt;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic                    take;

  assign out_valid = (cnt_r != '0);
  assign take      = out_valid && !out_stall;
  assign can_load  = (cnt_r == '0) || (take && cnt_r == IDX_W'(1));

  always_comb begin
    bytes_nxt = bytes_r;
    tail_nxt  = tail_r;
    err_nxt   = err_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      bytes_nxt = load_data.bytes;
      tail_nxt  = load_data.tail;
      err_nxt   = load_data.err;
      cnt_nxt   = load_data.cnt;
    end else if (take) begin
      // advance to the next byte of the burst
      bytes_nxt = {8'h00, bytes_r[MAX_RES-1:1]};
      tail_nxt  = {1'b0, tail_r[MAX_RES-1:1]};
      cnt_nxt   = cnt_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    tail_r  <= tail_nxt;
    err_r   <= err_nxt;
  end

  assign out_item.line_byte      = bytes_r[0];
  assign out_item.run_last       = (cnt_r == IDX_W'(1));
  assign out_item.frame_end      = tail_r[0];
  assign out_item.sequence_error = err_r;

endmodule

// ===== design/escaped_frame_encoder_top.sv =====
// Top level of the escaped frame encoder: input register, encoder, result register.
//
// Each input transaction carries one payload byte; the first of a frame also
// carries the frame length. The block sends each frame as head 0xFE, the length
// (saturated to MAX_PAYLOAD, not escaped), the payload with 0xFE/0xFF escaped as
// FE FC / FE FD, and tail 0xFF. A start while a frame is open, or a byte with no
// frame open, is dropped and reported as one result with sequence_error set and
// line_byte 0. Every result transaction is one line byte; run_last marks the last
// byte caused by an input item. Rate: one item causes 1 to 5 line bytes, and the
// result register sends one byte per cycle while out_stall is low: an ordinary
// payload byte gives 1 byte, an escaped one 2, the closing item of a longer frame
// up to 3, and a frame's first item up to 5. The input register takes a new
// transaction while the previous burst drains, and the next burst loads in the
// cycle its predecessor's last byte is taken. An input transaction passes
// through the input register and then the result register before its first
// line byte is sent. No clearing pass after reset; the block is ready at once.
module escaped_frame_encoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  efe_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output efe_pkg::out_item_t out_item
);
  import efe_pkg::*;

  in_item_t item_r;
  logic     item_vld_r, item_vld_nxt;
  logic     accept;
  logic     load;
  logic     can_load;
  burst_t   burst;

  // Hold the input item until the result register can take its burst.
  assign load     = item_vld_r && can_load;
  assign in_stall = item_vld_r && !can_load;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (accept) begin
      item_vld_nxt = 1'b1;
    end else if (load) begin
      item_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  efe_encoder u_encoder (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item_r),
    .load  (load),
    .burst (burst)
  );

  efe_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_data (burst),
    .out_stall (out_stall),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // An accepted transaction always lands in the input register.
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> item_vld_r)
    else $error("accepted transaction not held");

  // The frame tail always closes the item's burst.
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.frame_end) |-> out_item.run_last)
    else $error("frame tail not last byte of item");

  // A sequence error is a single zero byte.
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.sequence_error) |->
      (out_item.run_last && out_item.line_byte == ERR_BYTE))
    else $error("malformed sequence error result");

  // A new burst loads only when the output is empty or finishing.
  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !load)
    else $error("burst overwritten while stalled");

endmodule

// ===== verif/tb_escaped_frame_encoder_top.sv =====
// Testbench for the escaped frame encoder: framed, escaped byte streams under random flow control.
`timescale 1ns / 1ps

module tb_escaped_frame_encoder_top;
  import efe_pkg::*;

  // Abort when no transaction moves on either channel for this many cycles.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the receiver hold-off in the backpressure test.
  localparam int HOLD_CYCLES    = 300;
  // Cycles to wait after the last expected byte before the verdict.
  localparam int DRAIN_CYCLES   = 20;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  escaped_frame_encoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Encoder prediction: own copy of the framing state, line bytes queued in
  // the order the block must send them.
  // ---------------------------------------------------------------------------
  logic             frame_open_q;
  logic [LEN_W-1:0] bytes_left_q;
  out_item_t        line_q[$];

  out_item_t        burst_buf[MAX_RES];
  int               burst_cnt;

  int err_count     = 0;
  int items_sent    = 0;
  int in_idle_pct   = 0;
  int out_idle_pct  = 0;
  int hold_requests = 0;

  function automatic void add_line(logic [7:0] b, logic tail, logic err);
    burst_buf[burst_cnt] = '{line_byte: b, run_last: 1'b0, frame_end: tail,
                             sequence_error: err};
    burst_cnt++;
  endfunction

  // Escape 0xFE / 0xFF as head byte followed by the byte minus the offset.
  function automatic void add_payload(logic [7:0] b);
    if (b >= HEAD_BYTE) begin
      add_line(HEAD_BYTE, 1'b0, 1'b0);
      add_line(b - ESC_OFFSET, 1'b0, 1'b0);
    end else begin
      add_line(b, 1'b0, 1'b0);
    end
  endfunction

  // Work out the line bytes of one accepted input transaction and queue them.
  function automatic void encode_item(in_item_t it);
    logic [LEN_W-1:0] len;
    burst_cnt = 0;
    if (it.frame_start == frame_open_q) begin
      // Start while a frame is open, or a byte with no frame open: drop it.
      add_line(ERR_BYTE, 1'b0, 1'b1);
    end else if (it.frame_start) begin
      len = it.frame_length;
      if (int'(len) > MAX_PAYLOAD) len = LEN_W'(MAX_PAYLOAD);
      add_line(HEAD_BYTE, 1'b0, 1'b0);
      add_line(8'(len), 1'b0, 1'b0);
      if (len == '0) begin
        add_line(TAIL_BYTE, 1'b1, 1'b0);
      end else begin
        add_payload(it.payload_byte);
        bytes_left_q = len - LEN_W'(1);
        if (bytes_left_q == '0) add_line(TAIL_BYTE, 1'b1, 1'b0);
        else frame_open_q = 1'b1;
      end
    end else begin
      add_payload(it.payload_byte);
      if (bytes_left_q != '0) bytes_left_q = bytes_left_q - LEN_W'(1);
      if (bytes_left_q == '0) begin
        add_line(TAIL_BYTE, 1'b1, 1'b0);
        frame_open_q = 1'b0;
      end
    end
    burst_buf[burst_cnt-1].run_last = 1'b1;
    for (int i = 0; i < burst_cnt; i++) line_q.push_back(burst_buf[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted line byte with the oldest
  // expectation. Sample at the rising edge, before the block updates.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (line_q.size() == 0) begin
        if (err_count < 10)
          $display("unexpected line byte %02h (last %b end %b err %b)", out_item.line_byte,
                   out_item.run_last, out_item.frame_end, out_item.sequence_error);
        err_count++;
      end else begin
        exp_item = line_q.pop_front();
        if (out_item !== exp_item) begin
          if (err_count < 10)
            $display({"mismatch: expected %02h last %b end %b err %b, ",
                      "got %02h last %b end %b err %b"},
                     exp_item.line_byte, exp_item.run_last, exp_item.frame_end,
                     exp_item.sequence_error, out_item.line_byte, out_item.run_last,
                     out_item.frame_end, out_item.sequence_error);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls at the falling edge. A hold-off request from a
  // test keeps the stall high while a countdown from HOLD_CYCLES runs here.
  // ---------------------------------------------------------------------------
  int holds_served = 0;
  int hold_cnt     = 0;

  always @(negedge clk) begin
    if (holds_served < hold_requests) begin
      holds_served = holds_served + 1;
      hold_cnt     = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt  = hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_item(logic [7:0] b, logic s, logic [LEN_W-1:0] l);
    return '{payload_byte: b, frame_start: s, frame_length: l};
  endfunction

  // Bias payload toward the two escaped values.
  function automatic logic [7:0] rand_payload();
    if ($urandom_range(99) < 25) return $urandom_range(1) ? HEAD_BYTE : TAIL_BYTE;
    return 8'($urandom_range(255));
  endfunction

  // Mostly short frames, a few long ones.
  function automatic logic [LEN_W-1:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return LEN_W'($urandom_range(8));
    if (r < 93) return LEN_W'($urandom_range(30, 9));
    return LEN_W'($urandom_range(MAX_PAYLOAD, 31));
  endfunction

  // Offer one transaction at the falling edge, hold it until accepted, predict.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    encode_item(it);
    items_sent++;
  endtask

  // Send one frame with random content; optionally slip in stray starts.
  task automatic send_frame(input logic [LEN_W-1:0] len, input bit noisy);
    send_item(mk_item(rand_payload(), 1'b1, len));
    for (int i = 1; i < int'(len); i++) begin
      if (noisy && $urandom_range(99) < 5)
        send_item(mk_item(rand_payload(), 1'b1, LEN_W'($urandom)));
      send_item(mk_item(rand_payload(), 1'b0, LEN_W'($urandom)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero-length frames: payload is ignored, expect FE 00 FF.
  task automatic test_zero_length();
    send_item(mk_item(8'hFF, 1'b1, '0));
    send_item(mk_item(8'h00, 1'b1, '0));
  endtask

  // One-byte frames at the escape boundary; FE and FF give the five-byte burst.
  task automatic test_single_byte();
    send_item(mk_item(8'h00, 1'b1, 6'd1));
    send_item(mk_item(8'hFD, 1'b1, 6'd1));
    send_item(mk_item(8'hFE, 1'b1, 6'd1));
    send_item(mk_item(8'hFF, 1'b1, 6'd1));
  endtask

  // Escapes on the first, middle and last byte of a frame.
  task automatic test_escapes();
    send_item(mk_item(8'hFF, 1'b1, 6'd5));
    send_item(mk_item(8'hFE, 1'b0, 6'd63));
    send_item(mk_item(8'h7F, 1'b0, 6'd0));
    send_item(mk_item(8'h80, 1'b0, 6'd42));
    send_item(mk_item(8'hFF, 1'b0, 6'd21));
  endtask

  // Byte with no frame open, and start while a frame is open.
  task automatic test_sequence_errors();
    send_item(mk_item(8'hFF, 1'b0, 6'd63));
    send_item(mk_item(8'h01, 1'b1, 6'd3));
    send_item(mk_item(8'h55, 1'b1, 6'd0));
    send_item(mk_item(8'hFF, 1'b1, 6'd63));
    send_item(mk_item(8'h02, 1'b0, 6'd0));
    send_item(mk_item(8'hFE, 1'b0, 6'd63));
    send_item(mk_item(8'h00, 1'b0, 6'd0));
  endtask

  // Largest frame the length field allows.
  task automatic test_max_frame();
    send_frame(LEN_W'(MAX_PAYLOAD), 1'b0);
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_flow(input int n_items);
    int target;
    target       = items_sent + n_items;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (items_sent < target) send_frame(rand_len(), 1'b0);
  endtask

  // Random frames and noise with random idling on both sides.
  task automatic test_random_traffic(input int n_items);
    int target;
    target       = items_sent + n_items;
    in_idle_pct  = 33;
    out_idle_pct = 33;
    while (items_sent < target) begin
      if ($urandom_range(99) < 8)
        send_item(mk_item(rand_payload(), 1'b0, LEN_W'($urandom)));
      send_frame(rand_len(), 1'b1);
    end
  endtask

  // Hold off the receiver while the sender keeps offering; the block fills up.
  task automatic test_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 33;
    hold_requests++;
    send_frame(6'd20, 1'b0);
    send_frame(6'd12, 1'b1);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    frame_open_q = 1'b0;
    bytes_left_q = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part runs with light random stalls on both sides.
    in_idle_pct  = 33;
    out_idle_pct = 33;
    test_zero_length();
    test_single_byte();
    test_escapes();
    test_sequence_errors();

    test_max_frame();
    test_steady_flow(30);
    test_random_traffic(50);
    test_backpressure();
    test_random_traffic(30);

    @(negedge clk);
    in_valid <= 1'b0;

    // Wait for every expected byte, then a little longer for stray results.
    while (line_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && line_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
